>>> src/evm_pkg.sv
// Shared types, constants and the quarter-wave sine generator for the view matrix block.
// No dependencies; every other file in src imports this package.
package evm_pkg;

  localparam int          ONE_Q14     = 16384;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam int          NUM_ENTRIES = 9;
  localparam int          NUM_TRANS   = 3;

  typedef logic signed [15:0] evm_entry_t;
  typedef logic signed [31:0] evm_pos_t;

  // sines and cosines of yaw (1), pitch (2) and roll (3), Q1.14
  typedef struct packed {
    logic signed [15:0] s1;
    logic signed [15:0] c1;
    logic signed [15:0] s2;
    logic signed [15:0] c2;
    logic signed [15:0] s3;
    logic signed [15:0] c3;
  } evm_trig_t;

  // Sine of x * (pi/2) / 16384 for x in [0, 16384] as unsigned Q1.14.
  // Taylor series to the 11th power in Q2.30, each term truncated.
  // Used only on constants, to fill the lookup table.
  function automatic logic [14:0] quarter_sine(input logic [31:0] x);
    logic [63:0]        theta;
    logic [63:0]        theta2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    theta  = (64'(x) * HALF_PI_Q30) >> 14;
    theta2 = (theta * theta) >> 30;
    mag    = theta;
    sum    = signed'(theta);
    mag    = ((mag * theta2) >> 30) / 64'd6;
    sum    = sum - signed'(mag);
    mag    = ((mag * theta2) >> 30) / 64'd20;
    sum    = sum + signed'(mag);
    mag    = ((mag * theta2) >> 30) / 64'd42;
    sum    = sum - signed'(mag);
    mag    = ((mag * theta2) >> 30) / 64'd72;
    sum    = sum + signed'(mag);
    mag    = ((mag * theta2) >> 30) / 64'd110;
    sum    = sum - signed'(mag);
    if (sum < 0) begin
      sum = '0;
    end
    rnd = (unsigned'(sum) + 64'd32768) >> 16;
    if (rnd > 64'(ONE_Q14)) begin
      rnd = 64'(ONE_Q14);
    end
    return rnd[14:0];
  endfunction

endpackage

>>> src/evm_trig.sv
// Angle quantization and quarter-wave table lookup for sine and cosine, one register stage.
// Depends on evm_pkg.
module evm_trig import evm_pkg::*; #(
  parameter int TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] yaw,
  input  logic [15:0] pitch,
  input  logic [15:0] roll,
  output logic        out_valid,
  output evm_trig_t   trig
);

  localparam int          SHIFT   = 16 - TABLE_BITS;
  localparam int          ENTRIES = (1 << (TABLE_BITS - 2)) + 1;
  localparam int          IDX_W   = TABLE_BITS - 1;
  localparam logic [15:0] KEEP    = 16'(32'hFFFF << SHIFT);

  logic [14:0]        quarter_tbl [ENTRIES];
  logic [15:0]        ang         [6];
  logic signed [15:0] val         [6];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_tbl
    assign quarter_tbl[i] = quarter_sine(32'(i) << SHIFT);
  end

  // sin at the angle, cos at the angle plus a quarter turn
  assign ang[0] = yaw;
  assign ang[1] = yaw + 16'd16384;
  assign ang[2] = pitch;
  assign ang[3] = pitch + 16'd16384;
  assign ang[4] = roll;
  assign ang[5] = roll + 16'd16384;

  always_comb begin
    logic [15:0]      q;
    logic [14:0]      x;
    logic [IDX_W-1:0] idx;
    logic [14:0]      mag;
    for (int k = 0; k < 6; k++) begin
      q   = ang[k] & KEEP;
      x   = q[14] ? 15'(15'd16384 - {1'b0, q[13:0]}) : {1'b0, q[13:0]};
      idx = x[14:SHIFT];
      mag = quarter_tbl[idx];
      val[k] = q[15] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    trig.s1 <= val[0];
    trig.c1 <= val[1];
    trig.s2 <= val[2];
    trig.c2 <= val[3];
    trig.s3 <= val[4];
    trig.c3 <= val[5];
  end

endmodule

>>> src/evm_basis.sv
// Rotation basis: pair products, triple products, then rounding to Q1.14 (three stages).
// Depends on evm_pkg.
module evm_basis import evm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  evm_trig_t  trig,
  output logic       out_valid,
  output evm_entry_t mat [NUM_ENTRIES]
);

  logic               v2;
  logic               v3;
  logic signed [31:0] c1c3, s1s2, c1s2, c3s1, c1s3, s1s3, c2s3, c2c3, c2s1, c1c2;
  logic signed [15:0] s2_d, s3_d;
  logic signed [47:0] q42 [NUM_ENTRIES];

  function automatic evm_entry_t to_q14(input logic signed [47:0] v);
    logic signed [47:0] r;
    r = (v + 48'sd134217728) >>> 28;
    if (r > 48'sd16384) begin
      r = 48'sd16384;
    end else if (r < -48'sd16384) begin
      r = -48'sd16384;
    end
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v2        <= in_valid;
      v3        <= v2;
      out_valid <= v3;
    end
    // pair products, Q2.28
    c1c3 <= trig.c1 * trig.c3;
    s1s2 <= trig.s1 * trig.s2;
    c1s2 <= trig.c1 * trig.s2;
    c3s1 <= trig.c3 * trig.s1;
    c1s3 <= trig.c1 * trig.s3;
    s1s3 <= trig.s1 * trig.s3;
    c2s3 <= trig.c2 * trig.s3;
    c2c3 <= trig.c2 * trig.c3;
    c2s1 <= trig.c2 * trig.s1;
    c1c2 <= trig.c1 * trig.c2;
    s2_d <= trig.s2;
    s3_d <= trig.s3;
    // exact Q42 entries
    q42[0] <= (48'(c1c3) <<< 14) + 48'(s1s2) * 48'(s3_d);
    q42[1] <= 48'(c2s3) <<< 14;
    q42[2] <= 48'(c1s2) * 48'(s3_d) - (48'(c3s1) <<< 14);
    q42[3] <= 48'(c3s1) * 48'(s2_d) - (48'(c1s3) <<< 14);
    q42[4] <= 48'(c2c3) <<< 14;
    q42[5] <= 48'(c1c3) * 48'(s2_d) + (48'(s1s3) <<< 14);
    q42[6] <= 48'(c2s1) <<< 14;
    q42[7] <= -(48'(s2_d) <<< 28);
    q42[8] <= 48'(c1c2) <<< 14;
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      mat[k] <= to_q14(q42[k]);
    end
  end

endmodule

>>> src/evm_trans.sv
// View translation: entry-by-position products, then negated sums rounded and saturated.
// Two stages; also delays the matrix entries to line up. Depends on evm_pkg.
module evm_trans import evm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  evm_entry_t mat [NUM_ENTRIES],
  input  evm_pos_t   pos [NUM_TRANS],
  output logic       out_valid,
  output evm_entry_t mat_out [NUM_ENTRIES],
  output evm_pos_t   trans [NUM_TRANS]
);

  logic               v5;
  logic signed [47:0] prod  [NUM_ENTRIES];
  evm_entry_t         mat_d [NUM_ENTRIES];

  function automatic evm_pos_t finish(input logic signed [47:0] a,
                                      input logic signed [47:0] b,
                                      input logic signed [47:0] c);
    logic signed [49:0] s;
    s = -(50'(a) + 50'(b) + 50'(c));
    s = (s + 50'sd8192) >>> 14;
    if (s > 50'sd2147483647) begin
      s = 50'sd2147483647;
    end else if (s < -50'sd2147483648) begin
      s = -50'sd2147483648;
    end
    return s[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v5        <= in_valid;
      out_valid <= v5;
    end
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      prod[k]    <= 48'(mat[k]) * 48'(pos[k % NUM_TRANS]);
      mat_d[k]   <= mat[k];
      mat_out[k] <= mat_d[k];
    end
    for (int t = 0; t < NUM_TRANS; t++) begin
      trans[t] <= finish(prod[3*t], prod[3*t+1], prod[3*t+2]);
    end
  end

endmodule

>>> src/euler_yxz_view_matrix.sv
// Top level of the YXZ Euler-angle camera view matrix block.
// Depends on evm_pkg, evm_trig, evm_basis and evm_trans.
//
// Usage:
//   Drive yaw_angle, pitch_angle, roll_angle (binary angles, 32768 = pi) and
//   pos_x/y/z (Q16.16) and raise start for one cycle per item. A transfer
//   happens at every rising edge with start high and busy low; busy is
//   always low, so an item may enter in every cycle.
//   After a transfer, done is high for exactly one cycle with the
//   nine Q1.14 basis entries (right, up, fwd) and the three saturated Q16.16
//   translations on the result ports. The receiver cannot stall; capture
//   the result in the cycle that done marks.
//   Throughput: one item per cycle.
//   Stages: table lookup, pair products, triple products, rounding to Q1.14,
//   entry-by-position products, sum/round/saturate into the output register.
//   The sine table holds 2^(TRIG_TABLE_BITS-2)+1 quarter-wave entries, built
//   from constants at elaboration.
//   Reset (rst, synchronous) clears the valid pipeline; items in flight are
//   dropped and no done pulse follows until new items enter.
module euler_yxz_view_matrix import evm_pkg::*; #(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] yaw_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] roll_angle,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               done,
  output logic signed [15:0] right_x,
  output logic signed [15:0] right_y,
  output logic signed [15:0] right_z,
  output logic signed [15:0] up_x,
  output logic signed [15:0] up_y,
  output logic signed [15:0] up_z,
  output logic signed [15:0] fwd_x,
  output logic signed [15:0] fwd_y,
  output logic signed [15:0] fwd_z,
  output logic signed [31:0] trans_u,
  output logic signed [31:0] trans_v,
  output logic signed [31:0] trans_w
);

  localparam int POS_DELAY = 4;  // lookup + three basis stages

  logic       accept;
  logic       trig_valid;
  logic       basis_valid;
  evm_trig_t  trig;
  evm_entry_t mat      [NUM_ENTRIES];
  evm_entry_t mat_out  [NUM_ENTRIES];
  evm_pos_t   trans    [NUM_TRANS];
  evm_pos_t   pos_pipe [POS_DELAY][NUM_TRANS];

  // never hold off the sender: every stage advances each cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // carry the position alongside the angle work until the translation stage
  always_ff @(posedge clk) begin
    pos_pipe[0][0] <= pos_x;
    pos_pipe[0][1] <= pos_y;
    pos_pipe[0][2] <= pos_z;
    for (int d = 1; d < POS_DELAY; d++) begin
      pos_pipe[d] <= pos_pipe[d-1];
    end
  end

  evm_trig #(
    .TABLE_BITS(TRIG_TABLE_BITS)
  ) u_trig (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .yaw      (yaw_angle),
    .pitch    (pitch_angle),
    .roll     (roll_angle),
    .out_valid(trig_valid),
    .trig     (trig)
  );

  evm_basis u_basis (
    .clk      (clk),
    .rst      (rst),
    .in_valid (trig_valid),
    .trig     (trig),
    .out_valid(basis_valid),
    .mat      (mat)
  );

  evm_trans u_trans (
    .clk      (clk),
    .rst      (rst),
    .in_valid (basis_valid),
    .mat      (mat),
    .pos      (pos_pipe[POS_DELAY-1]),
    .out_valid(done),
    .mat_out  (mat_out),
    .trans    (trans)
  );

  assign right_x = mat_out[0];
  assign right_y = mat_out[1];
  assign right_z = mat_out[2];
  assign up_x    = mat_out[3];
  assign up_y    = mat_out[4];
  assign up_z    = mat_out[5];
  assign fwd_x   = mat_out[6];
  assign fwd_y   = mat_out[7];
  assign fwd_z   = mat_out[8];
  assign trans_u = trans[0];
  assign trans_v = trans[1];
  assign trans_w = trans[2];

  // every transfer yields a result on done
  a_start_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("transfer without result");

  // no result on done without an earlier transfer
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |-> ##6 !done)
    else $error("result without transfer");

  // the rounded entries fwd_y and right_x stay within plus and minus one
  a_entry_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (fwd_y <= 16'sd16384 && fwd_y >= -16'sd16384 &&
              right_x <= 16'sd16384 && right_x >= -16'sd16384))
    else $error("matrix entry out of range");

endmodule
